// File: hw/rtl/cmtr_pkg.sv
// Shared types, constants and helper functions for the CJK multibyte text reader.
// Used by the register, decode, queue and top-level RTL files; depends on nothing.
`default_nettype none
package cmtr_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CNT_EXT    = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [QCNT_BITS-1:0]  qcount_t;

  localparam logic [2:0] ENC_SINGLE = 3'd0;
  localparam logic [2:0] ENC_HANGUL = 3'd1;
  localparam logic [2:0] ENC_BIG5   = 3'd2;
  localparam logic [2:0] ENC_SJIS   = 3'd3;
  localparam logic [2:0] ENC_GB2312 = 3'd4;

  localparam logic REG_MB_ENABLE = 1'b0;
  localparam logic REG_ENCODING  = 1'b1;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_EXCL  = 8'h21;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_QUES  = 8'h3f;
  localparam logic [7:0] CH_CARET = 8'h5e;

  localparam logic [15:0] BIG5_PUNCT_LO = 16'ha140;
  localparam logic [15:0] BIG5_PUNCT_HI = 16'ha154;
  localparam logic [15:0] SJIS_PUNCT_LO = 16'h8140;
  localparam logic [15:0] SJIS_PUNCT_HI = 16'h8152;
  localparam logic [15:0] GB_PUNCT_LO   = 16'ha1a1;
  localparam logic [15:0] GB_PUNCT_HI   = 16'ha1ae;

  localparam logic [7:0] HANGUL_LEAD_LO  = 8'hb0;
  localparam logic [7:0] HANGUL_LEAD_HI  = 8'hc8;
  localparam logic [7:0] HIGH_TRAIL_LO   = 8'ha1;
  localparam logic [7:0] HIGH_TRAIL_HI   = 8'hfe;
  localparam logic [7:0] SJIS_LEAD_LO    = 8'h81;
  localparam logic [7:0] SJIS_LEAD_HI    = 8'h9f;
  localparam logic [7:0] SJIS_LEAD2_LO   = 8'he0;
  localparam logic [7:0] SJIS_LEAD2_HI   = 8'hef;
  localparam logic [7:0] LOW_TRAIL_LO    = 8'h40;
  localparam logic [7:0] LOW_TRAIL_HI    = 8'h7e;
  localparam logic [7:0] SJIS_TRAIL2_LO  = 8'h80;
  localparam logic [7:0] SJIS_TRAIL2_HI  = 8'hfc;
  localparam logic [7:0] BIG5_LEAD_LO    = 8'ha1;
  localparam logic [7:0] BIG5_LEAD_HI    = 8'hc6;
  localparam logic [7:0] BIG5_LEAD2_LO   = 8'hc9;
  localparam logic [7:0] BIG5_LEAD2_HI   = 8'hf9;
  localparam logic [7:0] GB_LEAD_LO      = 8'ha1;
  localparam logic [7:0] GB_LEAD_HI      = 8'hf7;

  typedef struct packed {
    logic       multibyte_enable;
    logic [2:0] encoding;
  } cfg_t;

  typedef struct packed {
    logic [15:0] char_code;
    logic        two_byte;
    logic        trailing_punct;
    logic        counted;
    logic        colour_code;
    logic [15:0] printable_count;
    logic        last_of_string;
  } result_t;

  typedef struct packed {
    logic [1:0] n_results;
    result_t    first;
    result_t    second;
    logic [7:0] held_byte;
    logic       held_valid;
    count_t     total;
  } dec_t;

  function automatic logic in_range(input logic [7:0] v, input logic [7:0] lo,
                                    input logic [7:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic count_t sat_inc(input count_t total, input logic bump);
    return (bump && (total != '1)) ? count_t'(total + 1'b1) : total;
  endfunction

  function automatic logic [15:0] show_count(input count_t total);
    logic [CNT_EXT-1:0] ext;
    ext = CNT_EXT'(total);
    return (ext > CNT_EXT'(16'hffff)) ? 16'hffff : ext[15:0];
  endfunction

  function automatic logic single_punct(input logic [7:0] b);
    logic p;
    case (b) inside
      CH_EXCL, CH_QUES, CH_COMMA, CH_DOT, CH_SEMI, CH_COLON: p = 1'b1;
      default: p = 1'b0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cmtr_in_if.sv
// Input channel of the text reader: valid/ready handshake with one text byte.
// Stands alone; no package needed.
`default_nettype none
interface cmtr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_string;

  modport source(output valid, output text_byte, output end_of_string, input ready);
  modport sink(input valid, input text_byte, input end_of_string, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cmtr_out_if.sv
// Output channel of the text reader: valid/ready handshake with one decoded character.
// Stands alone; no package needed.
`default_nettype none
interface cmtr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic        two_byte;
  logic        trailing_punct;
  logic        counted;
  logic        colour_code;
  logic [15:0] printable_count;
  logic        last_of_string;

  modport source(output valid, output char_code, output two_byte, output trailing_punct,
                 output counted, output colour_code, output printable_count,
                 output last_of_string, input ready);
  modport sink(input valid, input char_code, input two_byte, input trailing_punct,
               input counted, input colour_code, input printable_count,
               input last_of_string, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cmtr_apb_regs.sv
// APB configuration registers: multibyte enable and encoding select.
// Depends on cmtr_pkg.
`default_nettype none
module cmtr_apb_regs (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cmtr_pkg::cfg_t      cfg
);
  import cmtr_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (paddr[2])
        REG_MB_ENABLE: cfg.multibyte_enable <= pwdata[0];
        REG_ENCODING:  cfg.encoding         <= pwdata[2:0];
        default:       cfg                  <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MB_ENABLE: prdata = {31'b0, cfg.multibyte_enable};
      REG_ENCODING:  prdata = {29'b0, cfg.encoding};
      default:       prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/cmtr_decode.sv
// Character decision for one staged byte against the held lookahead byte.
// Pair check, colour code, punctuation and printable count; depends on cmtr_pkg.
`default_nettype none
module cmtr_decode (
  input  wire cmtr_pkg::cfg_t  cfg,
  input  wire logic            held_valid,
  input  wire logic [7:0]      held_byte,
  input  wire cmtr_pkg::count_t total,
  input  wire logic [7:0]      text_byte,
  input  wire logic            end_of_string,
  output cmtr_pkg::dec_t       dec
);
  import cmtr_pkg::*;

  logic        pair_ok;
  logic        pair_punct;
  logic [15:0] code;
  logic        is_colour;
  count_t      cnt0;
  count_t      cnt1;
  dec_t        pre;

  assign code = {held_byte, text_byte};

  always_comb begin
    pair_ok    = 1'b0;
    pair_punct = 1'b0;
    unique case (cfg.encoding)
      ENC_HANGUL: begin
        pair_ok = in_range(held_byte, HANGUL_LEAD_LO, HANGUL_LEAD_HI) &&
                  in_range(text_byte, HIGH_TRAIL_LO, HIGH_TRAIL_HI);
      end
      ENC_BIG5: begin
        pair_ok = (in_range(held_byte, BIG5_LEAD_LO, BIG5_LEAD_HI) ||
                   in_range(held_byte, BIG5_LEAD2_LO, BIG5_LEAD2_HI)) &&
                  (in_range(text_byte, LOW_TRAIL_LO, LOW_TRAIL_HI) ||
                   in_range(text_byte, HIGH_TRAIL_LO, HIGH_TRAIL_HI));
        pair_punct = (code >= BIG5_PUNCT_LO) && (code < BIG5_PUNCT_HI);
      end
      ENC_SJIS: begin
        pair_ok = (in_range(held_byte, SJIS_LEAD_LO, SJIS_LEAD_HI) ||
                   in_range(held_byte, SJIS_LEAD2_LO, SJIS_LEAD2_HI)) &&
                  (in_range(text_byte, LOW_TRAIL_LO, LOW_TRAIL_HI) ||
                   in_range(text_byte, SJIS_TRAIL2_LO, SJIS_TRAIL2_HI));
        pair_punct = (code >= SJIS_PUNCT_LO) && (code < SJIS_PUNCT_HI);
      end
      ENC_GB2312: begin
        pair_ok = in_range(held_byte, GB_LEAD_LO, GB_LEAD_HI) &&
                  in_range(text_byte, HIGH_TRAIL_LO, HIGH_TRAIL_HI);
        pair_punct = (code >= GB_PUNCT_LO) && (code < GB_PUNCT_HI);
      end
      default: begin
        pair_ok    = 1'b0;
        pair_punct = 1'b0;
      end
    endcase
    pair_ok    = pair_ok && cfg.multibyte_enable;
    pair_punct = pair_punct && pair_ok;
  end

  assign is_colour = (held_byte == CH_CARET) && in_range(text_byte, CH_ZERO, CH_NINE);

  always_comb begin
    pre            = '0;
    pre.held_byte  = held_byte;
    pre.held_valid = held_valid;

    if (!held_valid) begin
      if (!end_of_string) begin
        pre.held_byte  = text_byte;
        pre.held_valid = 1'b1;
      end else begin
        pre.n_results            = 2'd1;
        pre.first.char_code      = {8'h00, text_byte};
        pre.first.trailing_punct = single_punct(text_byte);
        pre.first.counted        = (text_byte != CH_LF) && (text_byte != CH_CR);
        pre.first.last_of_string = 1'b1;
      end
    end else if (pair_ok) begin
      pre.n_results            = 2'd1;
      pre.first.char_code      = code;
      pre.first.two_byte       = 1'b1;
      pre.first.trailing_punct = pair_punct;
      pre.first.counted        = 1'b1;
      pre.first.last_of_string = end_of_string;
      pre.held_valid           = 1'b0;
    end else if (is_colour) begin
      pre.n_results            = 2'd1;
      pre.first.char_code      = {8'h00, CH_CARET};
      pre.first.colour_code    = 1'b1;
      pre.first.last_of_string = end_of_string;
      pre.held_valid           = 1'b0;
    end else begin
      pre.n_results            = 2'd1;
      pre.first.char_code      = {8'h00, held_byte};
      pre.first.trailing_punct = single_punct(held_byte);
      pre.first.counted        = (held_byte != CH_LF) && (held_byte != CH_CR);
      if (end_of_string) begin
        pre.n_results             = 2'd2;
        pre.second.char_code      = {8'h00, text_byte};
        pre.second.trailing_punct = single_punct(text_byte);
        pre.second.counted        = (text_byte != CH_LF) && (text_byte != CH_CR);
        pre.second.last_of_string = 1'b1;
        pre.held_valid            = 1'b0;
      end else begin
        pre.held_byte = text_byte;
      end
    end

    if (end_of_string || !pre.held_valid) begin
      pre.held_byte = '0;
    end
    if (end_of_string) begin
      pre.held_valid = 1'b0;
    end
  end

  assign cnt0 = sat_inc(total, pre.first.counted);
  assign cnt1 = sat_inc(cnt0, pre.second.counted);

  always_comb begin
    dec                        = pre;
    dec.first.printable_count  = show_count(cnt0);
    dec.second.printable_count = show_count(cnt1);
    if (end_of_string) begin
      dec.total = '0;
    end else if (pre.n_results == 2'd1) begin
      dec.total = cnt0;
    end else begin
      dec.total = total;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/cmtr_result_queue.sv
// Result queue: takes up to two decoded characters per cycle, hands out one per transaction.
// Depends on cmtr_pkg and cmtr_out_if.
`default_nettype none
module cmtr_result_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [1:0] n_results,
  input  wire cmtr_pkg::result_t first,
  input  wire cmtr_pkg::result_t second,
  output logic            room,
  cmtr_out_if.source      char_out
);
  import cmtr_pkg::*;

  result_t q [QUEUE_DEPTH];
  result_t q_next [QUEUE_DEPTH];
  result_t shifted [QUEUE_DEPTH];
  qcount_t count;
  qcount_t count_next;
  qcount_t base;
  logic    pop;

  assign pop  = (count != '0) && char_out.ready;
  assign base = count - qcount_t'(pop);
  assign room = count <= qcount_t'(QUEUE_DEPTH - 2);

  always_comb begin
    shifted[QUEUE_DEPTH-1] = q[QUEUE_DEPTH-1];
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      shifted[i] = pop ? q[i+1] : q[i];
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (push && (n_results != 2'd0) && (base == qcount_t'(i))) begin
        q_next[i] = first;
      end else if (push && (n_results == 2'd2) && (base + 1'b1 == qcount_t'(i))) begin
        q_next[i] = second;
      end else begin
        q_next[i] = shifted[i];
      end
    end
    count_next = base + (push ? qcount_t'(n_results) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  assign char_out.valid           = count != '0;
  assign char_out.char_code       = q[0].char_code;
  assign char_out.two_byte        = q[0].two_byte;
  assign char_out.trailing_punct  = q[0].trailing_punct;
  assign char_out.counted         = q[0].counted;
  assign char_out.colour_code     = q[0].colour_code;
  assign char_out.printable_count = q[0].printable_count;
  assign char_out.last_of_string  = q[0].last_of_string;
endmodule
`default_nettype wire

// File: hw/rtl/cjk_multibyte_text_reader.sv
// Top level of the CJK multibyte text reader: input stage, lookahead state, decode, queue.
// Depends on cmtr_pkg, cmtr_in_if, cmtr_out_if, cmtr_apb_regs, cmtr_decode, cmtr_result_queue.
//
// The reader takes one text byte per clock cycle and turns the string into characters: a
// byte is registered in the input stage, decoded combinationally against the one held
// lookahead byte, and its zero, one or two results are pushed into a four-entry output
// queue while it has room; the head of the queue is offered on the output. A byte that
// completes a character, a colour code or a single byte gives one result; a byte that
// only fills the lookahead gives none; the final byte after an invalid pair gives two,
// and while results arrive faster than one per cycle the output port, which hands out one
// per cycle while ready is high, sets the pace. Input stalls only when the queue holds more
// than two results. Configuration must be written over APB at byte address 0 (multibyte
// enable) and 4 (encoding) only while the reader is idle; the block does not enforce this.
`default_nettype none
module cjk_multibyte_text_reader (
  input  wire logic        clk,
  input  wire logic        rst,
  cmtr_in_if.sink          text_in,
  cmtr_out_if.source       char_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import cmtr_pkg::*;

  cfg_t       cfg;
  dec_t       dec;
  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       stg_eos;
  logic       held_valid;
  logic [7:0] held_byte;
  count_t     total;
  logic       room;
  logic       consume;

  assign consume       = stg_valid && room;
  assign text_in.ready = !stg_valid || room;

  cmtr_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (text_in.valid && text_in.ready) begin
      stg_valid <= 1'b1;
    end else if (consume) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.valid && text_in.ready) begin
      stg_byte <= text_in.text_byte;
      stg_eos  <= text_in.end_of_string;
    end
  end

  cmtr_decode u_decode (
    .cfg           (cfg),
    .held_valid    (held_valid),
    .held_byte     (held_byte),
    .total         (total),
    .text_byte     (stg_byte),
    .end_of_string (stg_eos),
    .dec           (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_byte  <= '0;
      total      <= '0;
    end else if (consume) begin
      held_valid <= dec.held_valid;
      held_byte  <= dec.held_byte;
      total      <= dec.total;
    end
  end

  cmtr_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (consume),
    .n_results (dec.n_results),
    .first     (dec.first),
    .second    (dec.second),
    .room      (room),
    .char_out  (char_out)
  );
endmodule
`default_nettype wire

// File: hw/rtl/cmtr_checker.sv
// Port-level checks for the CJK multibyte text reader, bound to the top level.
// Depends on cjk_multibyte_text_reader and its output channel interface.
`default_nettype none
module cmtr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] char_code,
  input wire logic        two_byte,
  input wire logic        trailing_punct,
  input wire logic        counted,
  input wire logic        colour_code,
  input wire logic [15:0] printable_count
);

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(printable_count))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && counted |-> printable_count != 16'h0000)
    else $error("counted character with zero printable count");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && colour_code |-> char_code == 16'h005e && !two_byte && !counted &&
    !trailing_punct)
    else $error("malformed colour code result");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && two_byte |-> char_code[15] && counted && !colour_code)
    else $error("malformed two-byte result");
endmodule

bind cjk_multibyte_text_reader cmtr_checker u_cmtr_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (char_out.valid),
  .out_ready       (char_out.ready),
  .char_code       (char_out.char_code),
  .two_byte        (char_out.two_byte),
  .trailing_punct  (char_out.trailing_punct),
  .counted         (char_out.counted),
  .colour_code     (char_out.colour_code),
  .printable_count (char_out.printable_count)
);
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the CJK multibyte text reader: byte strings in, characters out.
// Predicts every character from its own model of the decoder and compares field by field.
// Depends on cmtr_pkg, cmtr_in_if, cmtr_out_if and cjk_multibyte_text_reader.
`default_nettype none
module tb_top;
  import cmtr_pkg::*;

  localparam int IDLE_NONE   = 0;
  localparam int IDLE_RANDOM = 1;
  localparam int IDLE_BURSTY = 2;

  localparam logic [2:0] ENC_SPARE_LO = 3'd5;
  localparam logic [2:0] ENC_SPARE_HI = 3'd7;

  typedef struct {
    logic [7:0]  b;
    logic        eos;
    int unsigned gap;
  } text_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cmtr_in_if  byte_ch ();
  cmtr_out_if char_ch ();

  cjk_multibyte_text_reader i_dut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (byte_ch),
    .char_out (char_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_item_t  bytes_to_send[$];
  result_t     expected_chars[$];
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int          tx_mode = IDLE_NONE;
  int          rx_mode = IDLE_NONE;
  int          phase_no = 0;
  int          fail_count = 0;
  logic        rx_hold = 1'b0;
  logic        byte_fire = 1'b0;
  logic        char_fire = 1'b0;

  // decoder state as the hardware should hold it
  logic       cfg_mb = 1'b0;
  logic [2:0] cfg_enc = ENC_SINGLE;
  logic [7:0] held_lead = '0;
  logic       held_ok = 1'b0;
  count_t     text_total = '0;

  logic [8:0] directed_text [21] = '{
    9'h141,
    9'h05e, 9'h030, 9'h05e, 9'h139,
    9'h0a1, 9'h040, 9'h0a1, 9'h053, 9'h0a1, 9'h054, 9'h0f9, 9'h0fe,
    9'h00a, 9'h00d, 9'h021, 9'h03f, 9'h02c, 9'h02e, 9'h03b, 9'h13a
  };
  logic [8:0] directed_tail [5] = '{9'h0ff, 9'h001, 9'h0a1, 9'h102, 9'h1a1};

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  function automatic int unsigned draw_wait(input int mode);
    if (mode == IDLE_NONE) return 0;
    if (mode == IDLE_BURSTY && $urandom_range(7, 0) != 0) return 0;
    return $urandom_range(12, 0);
  endfunction

  function void push_char(input logic [15:0] code, input logic two, input logic punct,
                          input logic cnt, input logic colour, input logic last);
    result_t r;
    if (cnt && text_total != '1) text_total = text_total + 1'b1;
    r.char_code       = code;
    r.two_byte        = two;
    r.trailing_punct  = punct;
    r.counted         = cnt;
    r.colour_code     = colour;
    r.printable_count = (text_total > count_t'(16'hffff)) ? 16'hffff : 16'(text_total);
    r.last_of_string  = last;
    expected_chars.push_back(r);
  endfunction

  function void push_single(input logic [7:0] b, input logic last);
    logic punct;
    punct = b == CH_EXCL || b == CH_QUES || b == CH_COMMA || b == CH_DOT ||
            b == CH_SEMI || b == CH_COLON;
    push_char({8'h00, b}, 1'b0, punct, b != CH_LF && b != CH_CR, 1'b0, last);
  endfunction

  function automatic logic pair_forms(input logic [7:0] lead, input logic [7:0] trail,
                                      output logic punct);
    logic [15:0] code;
    logic        ok;
    code  = {lead, trail};
    ok    = 1'b0;
    punct = 1'b0;
    if (cfg_mb) begin
      case (cfg_enc)
        ENC_HANGUL: begin
          ok = lead >= HANGUL_LEAD_LO && lead <= HANGUL_LEAD_HI &&
               trail >= HIGH_TRAIL_LO && trail <= HIGH_TRAIL_HI;
        end
        ENC_BIG5: begin
          ok = ((lead >= BIG5_LEAD_LO && lead <= BIG5_LEAD_HI) ||
                (lead >= BIG5_LEAD2_LO && lead <= BIG5_LEAD2_HI)) &&
               ((trail >= LOW_TRAIL_LO && trail <= LOW_TRAIL_HI) ||
                (trail >= HIGH_TRAIL_LO && trail <= HIGH_TRAIL_HI));
          punct = ok && code >= BIG5_PUNCT_LO && code < BIG5_PUNCT_HI;
        end
        ENC_SJIS: begin
          ok = ((lead >= SJIS_LEAD_LO && lead <= SJIS_LEAD_HI) ||
                (lead >= SJIS_LEAD2_LO && lead <= SJIS_LEAD2_HI)) &&
               ((trail >= LOW_TRAIL_LO && trail <= LOW_TRAIL_HI) ||
                (trail >= SJIS_TRAIL2_LO && trail <= SJIS_TRAIL2_HI));
          punct = ok && code >= SJIS_PUNCT_LO && code < SJIS_PUNCT_HI;
        end
        ENC_GB2312: begin
          ok = lead >= GB_LEAD_LO && lead <= GB_LEAD_HI &&
               trail >= HIGH_TRAIL_LO && trail <= HIGH_TRAIL_HI;
          punct = ok && code >= GB_PUNCT_LO && code < GB_PUNCT_HI;
        end
        default: ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

  function void decode_text_byte(input logic [7:0] b, input logic eos);
    logic punct;
    if (!held_ok) begin
      if (!eos) begin
        held_lead = b;
        held_ok   = 1'b1;
        return;
      end
      push_single(b, 1'b1);
    end else if (pair_forms(held_lead, b, punct)) begin
      push_char({held_lead, b}, 1'b1, punct, 1'b1, 1'b0, eos);
      held_ok = 1'b0;
    end else if (held_lead == CH_CARET && b >= CH_ZERO && b <= CH_NINE) begin
      push_char({8'h00, CH_CARET}, 1'b0, 1'b0, 1'b0, 1'b1, eos);
      held_ok = 1'b0;
    end else begin
      push_single(held_lead, 1'b0);
      if (eos) begin
        push_single(b, 1'b1);
        held_ok = 1'b0;
      end else begin
        held_lead = b;
      end
    end
    if (eos) begin
      held_ok    = 1'b0;
      held_lead  = '0;
      text_total = '0;
    end else if (!held_ok) begin
      held_lead = '0;
    end
  endfunction

  function void enqueue_byte(input logic [7:0] b, input logic eos);
    text_item_t t;
    t.b   = b;
    t.eos = eos;
    t.gap = draw_wait(tx_mode);
    bytes_to_send.push_back(t);
  endfunction

  function automatic logic [7:0] pick_byte(input logic [7:0] lo, input logic [7:0] hi);
    case ($urandom_range(7, 0))
      0: return lo;
      1: return hi;
      default: return 8'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [15:0] random_pair(input logic [2:0] enc);
    logic [7:0] lead;
    logic [7:0] trail;
    logic       lo_half;
    lo_half = 1'($urandom_range(1, 0));
    case (enc)
      ENC_HANGUL: begin
        lead  = pick_byte(HANGUL_LEAD_LO, HANGUL_LEAD_HI);
        trail = pick_byte(HIGH_TRAIL_LO, HIGH_TRAIL_HI);
      end
      ENC_BIG5: begin
        lead  = lo_half ? pick_byte(BIG5_LEAD_LO, BIG5_LEAD_HI)
                        : pick_byte(BIG5_LEAD2_LO, BIG5_LEAD2_HI);
        trail = $urandom_range(1, 0) ? pick_byte(LOW_TRAIL_LO, LOW_TRAIL_HI)
                                     : pick_byte(HIGH_TRAIL_LO, HIGH_TRAIL_HI);
      end
      ENC_SJIS: begin
        lead  = lo_half ? pick_byte(SJIS_LEAD_LO, SJIS_LEAD_HI)
                        : pick_byte(SJIS_LEAD2_LO, SJIS_LEAD2_HI);
        trail = $urandom_range(1, 0) ? pick_byte(LOW_TRAIL_LO, LOW_TRAIL_HI)
                                     : pick_byte(SJIS_TRAIL2_LO, SJIS_TRAIL2_HI);
      end
      ENC_GB2312: begin
        lead  = pick_byte(GB_LEAD_LO, GB_LEAD_HI);
        trail = pick_byte(HIGH_TRAIL_LO, HIGH_TRAIL_HI);
      end
      default: begin
        lead  = pick_byte(8'h80, 8'hff);
        trail = pick_byte(8'h01, 8'hff);
      end
    endcase
    // aim at the punctuation block and its edges
    if ($urandom_range(3, 0) == 0) begin
      case (enc)
        ENC_BIG5: begin
          lead  = BIG5_PUNCT_LO[15:8];
          trail = pick_byte(BIG5_PUNCT_LO[7:0], BIG5_PUNCT_HI[7:0]);
        end
        ENC_SJIS: begin
          lead  = SJIS_PUNCT_LO[15:8];
          trail = pick_byte(SJIS_PUNCT_LO[7:0], SJIS_PUNCT_HI[7:0]);
        end
        ENC_GB2312: begin
          lead  = GB_PUNCT_LO[15:8];
          trail = pick_byte(GB_PUNCT_LO[7:0], GB_PUNCT_HI[7:0]);
        end
        default: ;
      endcase
    end
    return {lead, trail};
  endfunction

  function automatic logic [7:0] random_mark();
    case ($urandom_range(5, 0))
      0: return CH_EXCL;
      1: return CH_QUES;
      2: return CH_COMMA;
      3: return CH_DOT;
      4: return CH_SEMI;
      default: return CH_COLON;
    endcase
  endfunction

  task automatic queue_string(input int len, output int added);
    logic [7:0]  s[$];
    logic [15:0] pair;
    while (s.size() < len) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3: begin
          pair = random_pair(cfg_enc);
          s.push_back(pair[15:8]);
          s.push_back(pair[7:0]);
        end
        4: begin
          s.push_back(CH_CARET);
          s.push_back(8'($urandom_range(CH_NINE, CH_ZERO)));
        end
        5: s.push_back(random_mark());
        6: s.push_back($urandom_range(1, 0) ? CH_LF : CH_CR);
        7: s.push_back(CH_CARET);
        default: s.push_back(8'($urandom_range(255, 1)));
      endcase
    end
    foreach (s[i]) enqueue_byte(s[i], i == s.size() - 1);
    added = s.size();
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MB_ENABLE) cfg_mb = value[0];
    else cfg_enc = value[2:0];
  endtask

  task automatic configure(input logic mb, input logic [2:0] enc);
    write_reg(REG_MB_ENABLE, {31'b0, mb});
    write_reg(REG_ENCODING, {29'b0, enc});
  endtask

  // hold until every byte is taken and every character has come back
  task automatic settle();
    while (bytes_to_send.size() != 0 || byte_ch.valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic mb, input logic [2:0] enc, input int tx,
                           input int rx, input int n_bytes);
    int sent;
    int added;
    sent = 0;
    settle();
    configure(mb, enc);
    tx_mode = tx;
    rx_mode = rx;
    while (sent < n_bytes) begin
      queue_string($urandom_range(12, 1), added);
      sent += added;
    end
    phase_no++;
  endtask

  always @(negedge clk) begin : drive_bytes
    text_item_t item;
    if (rst) begin
      byte_ch.valid         <= 1'b0;
      byte_ch.text_byte     <= '0;
      byte_ch.end_of_string <= 1'b0;
    end else if (!byte_ch.valid || byte_fire) begin
      if (tx_wait != 0 || bytes_to_send.size() == 0) begin
        if (tx_wait != 0) tx_wait--;
        byte_ch.valid <= 1'b0;
      end else begin
        item = bytes_to_send.pop_front();
        byte_ch.valid         <= 1'b1;
        byte_ch.text_byte     <= item.b;
        byte_ch.end_of_string <= item.eos;
        tx_wait = item.gap;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (rst) begin
      char_ch.ready <= 1'b0;
    end else begin
      if (rx_hold) begin
        char_ch.ready <= 1'b0;
      end else if (char_fire || !char_ch.ready) begin
        if (char_fire) rx_wait = draw_wait(rx_mode);
        if (rx_wait != 0) begin
          rx_wait--;
          char_ch.ready <= 1'b0;
        end else begin
          char_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_ports
    result_t want;
    byte_fire = !rst && byte_ch.valid && byte_ch.ready;
    char_fire = !rst && char_ch.valid && char_ch.ready;
    if (byte_fire) decode_text_byte(byte_ch.text_byte, byte_ch.end_of_string);
    if (char_fire) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h", char_ch.char_code));
      end else begin
        want = expected_chars.pop_front();
        check_field("char_code", char_ch.char_code, want.char_code);
        check_field("two_byte", 16'(char_ch.two_byte), 16'(want.two_byte));
        check_field("trailing_punct", 16'(char_ch.trailing_punct),
                    16'(want.trailing_punct));
        check_field("counted", 16'(char_ch.counted), 16'(want.counted));
        check_field("colour_code", 16'(char_ch.colour_code), 16'(want.colour_code));
        check_field("printable_count", char_ch.printable_count, want.printable_count);
        check_field("last_of_string", 16'(char_ch.last_of_string),
                    16'(want.last_of_string));
      end
    end
  end

  initial begin : long_receiver_stall
    wait (phase_no == 3);
    repeat (10) @(negedge clk);
    rx_hold <= 1'b1;
    repeat (250) @(negedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : run_limit
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    configure(1'b1, ENC_BIG5);
    tx_mode = IDLE_RANDOM;
    rx_mode = IDLE_RANDOM;
    foreach (directed_text[i]) enqueue_byte(directed_text[i][7:0], directed_text[i][8]);
    foreach (directed_tail[i]) enqueue_byte(directed_tail[i][7:0], directed_tail[i][8]);

    run_phase(1'b0, ENC_SINGLE,   IDLE_RANDOM, IDLE_RANDOM, 150);
    run_phase(1'b1, ENC_HANGUL,   IDLE_BURSTY, IDLE_BURSTY, 150);
    run_phase(1'b1, ENC_SJIS,     IDLE_NONE,   IDLE_RANDOM, 180);
    run_phase(1'b1, ENC_GB2312,   IDLE_RANDOM, IDLE_NONE,   160);
    run_phase(1'b1, ENC_BIG5,     IDLE_BURSTY, IDLE_RANDOM, 170);
    run_phase(1'b0, ENC_SJIS,     IDLE_RANDOM, IDLE_BURSTY, 120);
    run_phase(1'b1, ENC_SPARE_HI, IDLE_NONE,   IDLE_NONE,   100);
    run_phase(1'b1, ENC_SPARE_LO, IDLE_RANDOM, IDLE_RANDOM, 80);
    run_phase(1'b1, ENC_HANGUL,   IDLE_NONE,   IDLE_BURSTY, 120);
    run_phase(1'b1, ENC_GB2312,   IDLE_BURSTY, IDLE_RANDOM, 100);

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
